@@ design/json_string_unescape_utf8_macros.svh @@
// assertion macros shared by the json string unescaper modules
// no dependencies; included inside module bodies
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/jsu_pkg.sv @@
// shared types and constants of the json string unescaper
// no dependencies
package jsu_pkg;

    localparam int unsigned MAX_LEN = 65536;
    localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned OFF_W   = 17;
    localparam int unsigned CALC_W  = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QA_W        = $clog2(QUEUE_DEPTH);
    localparam int unsigned QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ESCAPE  = 2'd1;
    localparam logic [1:0] ERR_UNICODE = 2'd2;

    // one input item's worth of results, one to four beats
    typedef struct packed {
        logic [3:0][7:0]  data;     // data[0] goes out first
        logic [1:0]       n_m1;     // beats minus one
        logic             dvalid;   // beats carry real bytes
        logic             done;     // last beat closes the string
        logic [1:0]       err;
        logic [OFF_W-1:0] eoff;
    } job_t;

endpackage

@@ design/jsu_front.sv @@
// front part: parses escapes and builds one job per item with results
// depends on jsu_pkg and the assertion macro header
module jsu_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     in_byte,
    input  logic           last_in,
    input  logic           no_byte,
    input  logic           in_fire,
    output jsu_pkg::job_t  job,
    output logic           job_push
);
    import jsu_pkg::*;
    `include "json_string_unescape_utf8_macros.svh"

    typedef enum logic [2:0] {
        PH_PLAIN,
        PH_ESC,
        PH_QUAD,
        PH_WANT_BS,
        PH_WANT_U,
        PH_LOW
    } phase_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [1:0]      n_m1;
    } utf8_t;

    phase_t           phase_reg, phase_next;
    logic [15:0]      hex_reg, hex_next;
    logic [9:0]       high_reg, high_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [OFF_W-1:0] mark_reg, mark_next;
    logic             pbad_reg, pbad_next;
    logic [OFF_W-1:0] ppos_reg, ppos_next;
    logic             failed_reg, failed_next;

    logic [POS_W-1:0] p;
    logic             d_ok;
    logic [3:0]       d_val;
    logic [15:0]      hex_new;
    logic             pbad_now;
    logic [OFF_W-1:0] ppos_now;
    logic [1:0]       err;
    logic [OFF_W-1:0] eoff;
    logic             one_en;
    logic [7:0]       one_byte;
    logic             cp_en;
    logic [20:0]      cp;
    utf8_t            enc;
    logic             end_str;

    function automatic logic [OFF_W-1:0] to_off(input logic [POS_W-1:0] x);
        return OFF_W'(CALC_W'(x));
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] v);
        utf8_t r;
        r = '0;
        if (v <= 21'h7f)
        begin
            r.b[0] = v[7:0];
            r.n_m1 = 2'd0;
        end
        else if (v <= 21'h7ff)
        begin
            r.b[0] = 8'hc0 | {3'b000, v[10:6]};
            r.b[1] = 8'h80 | {2'b00, v[5:0]};
            r.n_m1 = 2'd1;
        end
        else if (v <= 21'hffff)
        begin
            r.b[0] = 8'he0 | {4'b0000, v[15:12]};
            r.b[1] = 8'h80 | {2'b00, v[11:6]};
            r.b[2] = 8'h80 | {2'b00, v[5:0]};
            r.n_m1 = 2'd2;
        end
        else
        begin
            r.b[0] = 8'hf0 | {5'b00000, v[20:18]};
            r.b[1] = 8'h80 | {2'b00, v[17:12]};
            r.b[2] = 8'h80 | {2'b00, v[11:6]};
            r.b[3] = 8'h80 | {2'b00, v[5:0]};
            r.n_m1 = 2'd3;
        end
        return r;
    endfunction

    // hex digit decode
    always_comb
    begin
        d_ok  = 1'b1;
        d_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            d_val = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            d_val = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            d_val = 4'(in_byte - 8'h37);
        else
            d_ok = 1'b0;
    end

    assign p        = pos_reg;
    assign hex_new  = {hex_reg[11:0], d_val};
    assign pbad_now = pbad_reg | ~d_ok;
    assign ppos_now = pbad_reg ? ppos_reg : to_off(p);
    assign enc      = utf8_encode(cp);

    always_comb
    begin
        phase_next  = phase_reg;
        hex_next    = hex_reg;
        high_next   = high_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        mark_next   = mark_reg;
        pbad_next   = pbad_reg;
        ppos_next   = ppos_reg;
        failed_next = failed_reg;
        err         = ERR_NONE;
        eoff        = '0;
        one_en      = 1'b0;
        one_byte    = 8'h00;
        cp_en       = 1'b0;
        cp          = '0;
        end_str     = 1'b0;
        job         = '0;
        job_push    = 1'b0;

        if (in_fire)
        begin
            if (failed_reg)
            begin
                end_str = last_in;
            end
            else
            begin
                if (!no_byte)
                begin
                    if (pos_reg < POS_W'(MAX_LEN))
                        pos_next = pos_reg + POS_W'(1);
                    unique case (phase_reg)
                        PH_PLAIN:
                        begin
                            if (in_byte == 8'h5c)
                            begin
                                mark_next  = to_off(p);
                                phase_next = PH_ESC;
                            end
                            else
                            begin
                                one_en   = 1'b1;
                                one_byte = in_byte;
                            end
                        end
                        PH_ESC:
                        begin
                            phase_next = PH_PLAIN;
                            unique case (in_byte)
                                8'h22, 8'h5c, 8'h2f:
                                begin
                                    one_en   = 1'b1;
                                    one_byte = in_byte;
                                end
                                8'h62: begin one_en = 1'b1; one_byte = 8'h08; end
                                8'h66: begin one_en = 1'b1; one_byte = 8'h0c; end
                                8'h6e: begin one_en = 1'b1; one_byte = 8'h0a; end
                                8'h72: begin one_en = 1'b1; one_byte = 8'h0d; end
                                8'h74: begin one_en = 1'b1; one_byte = 8'h09; end
                                8'h75:
                                begin
                                    phase_next = PH_QUAD;
                                    hex_next   = '0;
                                    cnt_next   = '0;
                                    pbad_next  = 1'b0;
                                end
                                default:
                                begin
                                    err  = ERR_ESCAPE;
                                    eoff = to_off(p);
                                end
                            endcase
                        end
                        PH_QUAD, PH_LOW:
                        begin
                            hex_next  = hex_new;
                            pbad_next = pbad_now;
                            ppos_next = ppos_now;
                            cnt_next  = cnt_reg + 2'd1;
                            if (cnt_reg == 2'd3)
                            begin
                                phase_next = PH_PLAIN;
                                if (pbad_now)
                                begin
                                    err  = ERR_UNICODE;
                                    eoff = ppos_now;
                                end
                                else if (phase_reg == PH_QUAD)
                                begin
                                    if (hex_new >= 16'hd800 && hex_new <= 16'hdbff)
                                    begin
                                        // high surrogate, wait for the low half
                                        high_next  = hex_new[9:0];
                                        mark_next  = OFF_W'(CALC_W'(p) + CALC_W'(1));
                                        phase_next = PH_WANT_BS;
                                    end
                                    else if (hex_new >= 16'hdc00 && hex_new <= 16'hdfff)
                                    begin
                                        err  = ERR_UNICODE;
                                        eoff = to_off((p >= POS_W'(3)) ? p - POS_W'(3) : '0);
                                    end
                                    else
                                    begin
                                        cp_en = 1'b1;
                                        cp    = {5'b00000, hex_new};
                                    end
                                end
                                else
                                begin
                                    if (hex_new < 16'hdc00 || hex_new > 16'hdfff)
                                    begin
                                        err  = ERR_UNICODE;
                                        eoff = to_off((p >= POS_W'(3)) ? p - POS_W'(3) : '0);
                                    end
                                    else
                                    begin
                                        // 0x10000 + (high << 10) + low
                                        cp_en = 1'b1;
                                        cp    = {11'(high_reg) + 11'd64, hex_new[9:0]};
                                    end
                                end
                            end
                        end
                        PH_WANT_BS:
                        begin
                            if (in_byte == 8'h5c)
                                phase_next = PH_WANT_U;
                            else
                            begin
                                err  = ERR_UNICODE;
                                eoff = mark_reg;
                            end
                        end
                        PH_WANT_U:
                        begin
                            if (in_byte == 8'h75)
                            begin
                                phase_next = PH_LOW;
                                hex_next   = '0;
                                cnt_next   = '0;
                                pbad_next  = 1'b0;
                            end
                            else
                            begin
                                err  = ERR_UNICODE;
                                eoff = mark_reg;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_PLAIN;
                        end
                    endcase
                end

                // end of string inside an escape
                if (err == ERR_NONE && last_in)
                begin
                    unique case (phase_next)
                        PH_PLAIN:
                        begin
                        end
                        PH_ESC:
                        begin
                            err  = ERR_ESCAPE;
                            eoff = mark_next;
                        end
                        PH_QUAD:
                        begin
                            err  = ERR_UNICODE;
                            eoff = to_off(pos_next);
                        end
                        default:
                        begin
                            err  = ERR_UNICODE;
                            eoff = mark_next;
                        end
                    endcase
                end

                if (err != ERR_NONE)
                begin
                    job.err   = err;
                    job.eoff  = eoff;
                    job.done  = 1'b1;
                    job_push  = 1'b1;
                    end_str   = last_in;
                    failed_next = ~last_in;
                end
                else
                begin
                    end_str  = last_in;
                    job.done = last_in;
                    if (one_en)
                    begin
                        job.dvalid  = 1'b1;
                        job.data[0] = one_byte;
                        job_push    = 1'b1;
                    end
                    else if (cp_en)
                    begin
                        job.dvalid = 1'b1;
                        job.data   = enc.b;
                        job.n_m1   = enc.n_m1;
                        job_push   = 1'b1;
                    end
                    else if (last_in)
                    begin
                        job_push = 1'b1;
                    end
                end
            end

            // string closed: back to the reset state
            if (end_str)
            begin
                phase_next  = PH_PLAIN;
                hex_next    = '0;
                high_next   = '0;
                cnt_next    = '0;
                pos_next    = '0;
                mark_next   = '0;
                pbad_next   = 1'b0;
                ppos_next   = '0;
                failed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PLAIN;
            hex_reg    <= '0;
            high_reg   <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            mark_reg   <= '0;
            pbad_reg   <= 1'b0;
            ppos_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hex_reg    <= hex_next;
            high_reg   <= high_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            mark_reg   <= mark_next;
            pbad_reg   <= pbad_next;
            ppos_reg   <= ppos_next;
            failed_reg <= failed_next;
        end
    end

    `JSU_ASSERT_NOW(a_failed_silent, clk, rst_n, in_fire && failed_reg, !job_push,
        "job pushed after an error")
    `JSU_ASSERT_NOW(a_err_single, clk, rst_n, job_push && job.err != ERR_NONE,
        !job.dvalid && job.done && job.n_m1 == 2'd0, "error job not a single closing beat")
    `JSU_ASSERT_NEXT(a_last_resets, clk, rst_n, in_fire && last_in,
        phase_reg == PH_PLAIN && pos_reg == '0 && !failed_reg, "state not cleared after last")

endmodule

@@ design/jsu_queue.sv @@
// short job queue between the front and back parts
// depends on jsu_pkg
module jsu_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  jsu_pkg::job_t  wr_job,
    input  logic           rd_en,
    output jsu_pkg::job_t  head,
    output logic           head_valid,
    output logic           is_full
);
    import jsu_pkg::*;

    job_t            slot_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wptr_reg, rptr_reg;
    logic [QC_W-1:0] count_reg;

    assign head       = slot_reg[rptr_reg];
    assign head_valid = (count_reg != '0);
    assign is_full    = (count_reg == QC_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= wptr_reg + QA_W'(1);
            if (rd_en)
                rptr_reg <= rptr_reg + QA_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + QC_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - QC_W'(1);
        end
    end

endmodule

@@ design/jsu_back.sv @@
// back part: splits each job into result beats behind an output register
// depends on jsu_pkg and the assertion macro header
module jsu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  jsu_pkg::job_t    head,
    input  logic             head_valid,
    output logic             head_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             run_last,
    output logic             string_done,
    output logic [1:0]       error_code,
    output logic [jsu_pkg::OFF_W-1:0] err_offset
);
    import jsu_pkg::*;
    `include "json_string_unescape_utf8_macros.svh"

    logic [1:0]       idx_reg;
    logic             full_reg;
    logic [7:0]       byte_reg;
    logic             bval_reg;
    logic             last_reg;
    logic             done_reg;
    logic [1:0]       err_reg;
    logic [OFF_W-1:0] eoff_reg;
    logic             load;
    logic             beat_last;

    assign load      = head_valid && (!full_reg || pop);
    assign beat_last = (idx_reg == head.n_m1);
    assign head_pop  = load && beat_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                full_reg <= 1'b1;
                idx_reg  <= beat_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.dvalid ? head.data[idx_reg] : 8'h00;
            bval_reg <= head.dvalid;
            last_reg <= beat_last;
            done_reg <= head.done && beat_last;
            err_reg  <= head.err;
            eoff_reg <= head.eoff;
        end
    end

    assign empty        = ~full_reg;
    assign out_byte     = byte_reg;
    assign out_valid    = bval_reg;
    assign run_last     = last_reg;
    assign string_done  = done_reg;
    assign error_code   = err_reg;
    assign err_offset   = eoff_reg;

    `JSU_ASSERT_NOW(a_idx_in_job, clk, rst_n, head_valid, idx_reg <= head.n_m1,
        "beat index past end of job")
    `JSU_ASSERT_NOW(a_done_is_last, clk, rst_n, full_reg && done_reg, last_reg,
        "string end not on the last beat of an item")
    `JSU_ASSERT_NOW(a_err_beat, clk, rst_n, full_reg && err_reg != ERR_NONE,
        !bval_reg && done_reg && last_reg, "error beat carries data")

endmodule

@@ design/json_string_unescape_utf8.sv @@
// top level of the json string unescaper: front, job queue and back
// depends on jsu_pkg, jsu_front, jsu_queue and jsu_back
//
// Unescapes a JSON string body fed one raw byte per beat and returns UTF-8
// bytes. Both sides look like a queue: push/full for input, empty/pop for
// results. An input beat is taken every cycle that full is low; full rises
// only when the four-entry job queue between the parser and the output
// stage fills up. Each input beat yields zero to four result beats: plain
// bytes and simple escapes give one, a \uXXXX quad gives one to three, a
// surrogate pair gives four on its low quad, and the beat with last_in set
// gives at least one (out_valid low if it has no byte) unless the string
// already failed. The output stage emits one result beat per cycle, so with
// pop held high the sustained rate is one input beat per cycle as long as
// escapes keep the output no larger than the input; a long run of multi-byte
// code points is limited by that one-beat-per-cycle output register. On an
// error a single beat with string_done, error_code and err_offset closes the
// string; later bytes of that string, up to and including its last beat,
// give no result. The receiver is expected to drop the bytes already
// delivered for that string.
module json_string_unescape_utf8
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                in_byte,
    input  logic                      last_in,
    input  logic                      no_byte,
    input  logic                      push,
    output logic                      full,
    output logic [7:0]                out_byte,
    output logic                      out_valid,
    output logic                      run_last,
    output logic                      string_done,
    output logic [1:0]                error_code,
    output logic [jsu_pkg::OFF_W-1:0] err_offset,
    output logic                      empty,
    input  logic                      pop
);
    import jsu_pkg::*;

    logic in_fire;
    job_t front_job;
    logic front_push;
    job_t q_head;
    logic q_valid;
    logic q_pop;
    logic q_full;

    assign full    = q_full;
    assign in_fire = push && !q_full;

    // parser: one input beat per cycle while full is low, into at most one job
    jsu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_byte),
        .last_in  (last_in),
        .no_byte  (no_byte),
        .in_fire  (in_fire),
        .job      (front_job),
        .job_push (front_push)
    );

    // decouples the parser from result delivery
    jsu_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (front_push),
        .wr_job     (front_job),
        .rd_en      (q_pop),
        .head       (q_head),
        .head_valid (q_valid),
        .is_full    (q_full)
    );

    // output stage: one result beat per cycle while pop is high
    jsu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (q_valid),
        .head_pop     (q_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .run_last     (run_last),
        .string_done  (string_done),
        .error_code   (error_code),
        .err_offset   (err_offset)
    );

endmodule

@@ tb/sv/json_string_unescape_utf8_tb.sv @@
// self-checking testbench for the json string unescaper, bytes in and utf-8 bytes out
// depends on jsu_pkg and json_string_unescape_utf8; a directed table, then random
// strings, checked against a behavioral parser model or hand-written pinned results
module json_string_unescape_utf8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // character codes the parser reacts to
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    // letters that follow a backslash in a two-byte escape: " \ / b f n r t
    localparam logic [7:0] ESC_LETTERS [8] = '{8'h22, 8'h5c, 8'h2f, 8'h62,
                                               8'h66, 8'h6e, 8'h72, 8'h74};

    localparam int N_RANDOM_BEATS = 130;

    typedef enum logic [2:0] {
        ST_TEXT,        // plain bytes
        ST_ESC,         // seen a backslash
        ST_QUAD,        // inside a first \u quad
        ST_PAIR_BS,     // high surrogate done, backslash required
        ST_PAIR_U,      // backslash seen, u required
        ST_LOW_QUAD     // inside the low surrogate quad
    } parse_state_t;

    // one result beat as it appears on the ports
    typedef struct packed {
        logic [7:0]       data;
        logic             valid;
        logic             run_last;
        logic             done;
        logic [1:0]       err;
        logic [OFF_W-1:0] off;
    } result_beat_t;

    // one input beat of the stimulus; pinned rows carry a hand-written result
    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         nob;
        logic         pinned;
        result_beat_t pin;
    } stim_beat_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic [7:0]       in_byte      = 8'h00;
    logic             last_in      = 1'b0;
    logic             no_byte      = 1'b0;
    logic             push         = 1'b0;
    logic             pop          = 1'b0;
    logic             full;
    logic [7:0]       out_byte;
    logic             out_valid;
    logic             run_last;
    logic             string_done;
    logic [1:0]       error_code;
    logic [OFF_W-1:0] err_offset;
    logic             empty;

    stim_beat_t   stim_q[$];
    logic [7:0]   str_bytes[$];        // body of the random string being built
    result_beat_t step_beats[$];       // what the model says one input beat gives
    result_beat_t predicted_beats[$];  // results still owed by the block
    int           n_fail = 0;

    // parser model state
    parse_state_t ps_state;
    logic [15:0]  ps_accum;
    logic [9:0]   ps_high10;
    int           ps_digits;
    int unsigned  ps_pos;
    int unsigned  ps_mark;
    logic         ps_bad_pending;
    int unsigned  ps_bad_pos;
    logic         ps_failed;

    json_string_unescape_utf8 dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .last_in      (last_in),
        .no_byte      (no_byte),
        .push         (push),
        .full         (full),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .run_last     (run_last),
        .string_done  (string_done),
        .error_code   (error_code),
        .err_offset   (err_offset),
        .empty        (empty),
        .pop          (pop)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    task automatic reset_parser();
        ps_state       = ST_TEXT;
        ps_accum       = '0;
        ps_high10      = '0;
        ps_digits      = 0;
        ps_pos         = 0;
        ps_mark        = 0;
        ps_bad_pending = 1'b0;
        ps_bad_pos     = 0;
        ps_failed      = 1'b0;
    endtask

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    task automatic push_beat(logic [7:0] b, logic v, logic [1:0] e, int unsigned off);
        result_beat_t r;
        r       = '0;
        r.data  = b;
        r.valid = v;
        r.err   = e;
        r.off   = off[OFF_W-1:0];
        step_beats.push_back(r);
    endtask

    task automatic push_utf8(int unsigned cp);
        if (cp <= 32'h7f)
        begin
            push_beat(cp[7:0], 1'b1, ERR_NONE, 0);
        end
        else if (cp <= 32'h7ff)
        begin
            push_beat({3'b110, cp[10:6]}, 1'b1, ERR_NONE, 0);
            push_beat({2'b10, cp[5:0]}, 1'b1, ERR_NONE, 0);
        end
        else if (cp <= 32'hffff)
        begin
            push_beat({4'b1110, cp[15:12]}, 1'b1, ERR_NONE, 0);
            push_beat({2'b10, cp[11:6]}, 1'b1, ERR_NONE, 0);
            push_beat({2'b10, cp[5:0]}, 1'b1, ERR_NONE, 0);
        end
        else
        begin
            push_beat({5'b11110, cp[20:18]}, 1'b1, ERR_NONE, 0);
            push_beat({2'b10, cp[17:12]}, 1'b1, ERR_NONE, 0);
            push_beat({2'b10, cp[11:6]}, 1'b1, ERR_NONE, 0);
            push_beat({2'b10, cp[5:0]}, 1'b1, ERR_NONE, 0);
        end
    endtask

    // advance the model by one accepted input beat; results land in step_beats
    task automatic unescape_beat(logic [7:0] c, logic last, logic nob);
        int unsigned  p;
        int unsigned  first;
        int           d;
        logic [1:0]   e;
        int unsigned  eoff;
        result_beat_t r;
        step_beats.delete();
        e    = ERR_NONE;
        eoff = 0;
        // after an error the rest of the string is swallowed
        if (ps_failed)
        begin
            if (last)
                reset_parser();
            return;
        end
        if (!nob)
        begin
            p = ps_pos;
            if (ps_pos < MAX_LEN)
                ps_pos++;
            case (ps_state)
                ST_TEXT:
                begin
                    if (c == CH_BSLASH)
                    begin
                        ps_mark  = p;
                        ps_state = ST_ESC;
                    end
                    else
                    begin
                        push_beat(c, 1'b1, ERR_NONE, 0);
                    end
                end
                ST_ESC:
                begin
                    ps_state = ST_TEXT;
                    case (c)
                        8'h22, CH_BSLASH, 8'h2f: push_beat(c, 1'b1, ERR_NONE, 0);
                        8'h62: push_beat(8'h08, 1'b1, ERR_NONE, 0);
                        8'h66: push_beat(8'h0c, 1'b1, ERR_NONE, 0);
                        8'h6e: push_beat(8'h0a, 1'b1, ERR_NONE, 0);
                        8'h72: push_beat(8'h0d, 1'b1, ERR_NONE, 0);
                        8'h74: push_beat(8'h09, 1'b1, ERR_NONE, 0);
                        CH_U:
                        begin
                            ps_state       = ST_QUAD;
                            ps_accum       = '0;
                            ps_digits      = 0;
                            ps_bad_pending = 1'b0;
                        end
                        default:
                        begin
                            e    = ERR_ESCAPE;
                            eoff = p;
                        end
                    endcase
                end
                ST_QUAD, ST_LOW_QUAD:
                begin
                    d = hex_nibble(c);
                    // first bad digit is held until the quad length is known
                    if (d < 0)
                    begin
                        if (!ps_bad_pending)
                        begin
                            ps_bad_pending = 1'b1;
                            ps_bad_pos     = p;
                        end
                        d = 0;
                    end
                    ps_accum = {ps_accum[11:0], d[3:0]};
                    ps_digits++;
                    if (ps_digits >= 4)
                    begin
                        first = (p >= 3) ? p - 3 : 0;
                        if (ps_bad_pending)
                        begin
                            e        = ERR_UNICODE;
                            eoff     = ps_bad_pos;
                            ps_state = ST_TEXT;
                        end
                        else if (ps_state == ST_QUAD)
                        begin
                            if (ps_accum >= 16'hd800 && ps_accum <= 16'hdbff)
                            begin
                                ps_high10 = 10'(ps_accum - 16'hd800);
                                ps_mark   = p + 1;
                                ps_state  = ST_PAIR_BS;
                            end
                            else
                            begin
                                if (ps_accum >= 16'hdc00 && ps_accum <= 16'hdfff)
                                begin
                                    e    = ERR_UNICODE;
                                    eoff = first;
                                end
                                else
                                begin
                                    push_utf8(32'(ps_accum));
                                end
                                ps_state = ST_TEXT;
                            end
                        end
                        else
                        begin
                            if (ps_accum < 16'hdc00 || ps_accum > 16'hdfff)
                            begin
                                e    = ERR_UNICODE;
                                eoff = first;
                            end
                            else
                            begin
                                push_utf8(32'h10000 + ({22'd0, ps_high10} << 10)
                                          + 32'(ps_accum - 16'hdc00));
                            end
                            ps_state = ST_TEXT;
                        end
                    end
                end
                ST_PAIR_BS:
                begin
                    if (c == CH_BSLASH)
                    begin
                        ps_state = ST_PAIR_U;
                    end
                    else
                    begin
                        e    = ERR_UNICODE;
                        eoff = ps_mark;
                    end
                end
                default:
                begin
                    if (c == CH_U)
                    begin
                        ps_state       = ST_LOW_QUAD;
                        ps_accum       = '0;
                        ps_digits      = 0;
                        ps_bad_pending = 1'b0;
                    end
                    else
                    begin
                        e    = ERR_UNICODE;
                        eoff = ps_mark;
                    end
                end
            endcase
        end
        // string ends in the middle of something
        if (e == ERR_NONE && last)
        begin
            case (ps_state)
                ST_TEXT:
                begin
                end
                ST_ESC:
                begin
                    e    = ERR_ESCAPE;
                    eoff = ps_mark;
                end
                ST_QUAD:
                begin
                    e    = ERR_UNICODE;
                    eoff = ps_pos;
                end
                default:
                begin
                    e    = ERR_UNICODE;
                    eoff = ps_mark;
                end
            endcase
            if (e == ERR_NONE && step_beats.size() == 0)
                push_beat(8'h00, 1'b0, ERR_NONE, 0);
        end
        if (e != ERR_NONE)
        begin
            step_beats.delete();
            push_beat(8'h00, 1'b0, e, eoff);
            r      = step_beats.pop_back();
            r.done = 1'b1;
            step_beats.push_back(r);
            if (last)
                reset_parser();
            else
                ps_failed = 1'b1;
        end
        else if (last)
        begin
            r      = step_beats.pop_back();
            r.done = 1'b1;
            step_beats.push_back(r);
            reset_parser();
        end
        if (step_beats.size() > 0)
        begin
            r          = step_beats.pop_back();
            r.run_last = 1'b1;
            step_beats.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_beat(logic [7:0] d, logic l, logic n);
        stim_beat_t s;
        s      = '0;
        s.data = d;
        s.last = l;
        s.nob  = n;
        stim_q.push_back(s);
    endtask

    task automatic add_pinned(logic [7:0] d, logic l, logic n, result_beat_t pin);
        stim_beat_t s;
        s        = '0;
        s.data   = d;
        s.last   = l;
        s.nob    = n;
        s.pinned = 1'b1;
        s.pin    = pin;
        stim_q.push_back(s);
    endtask

    // single result beat of a step, written by hand
    function automatic result_beat_t only_beat(logic [7:0] d, logic v, logic done,
                                               logic [1:0] e, int unsigned off);
        result_beat_t r;
        r          = '0;
        r.data     = d;
        r.valid    = v;
        r.run_last = 1'b1;
        r.done     = done;
        r.err      = e;
        r.off      = off[OFF_W-1:0];
        return r;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    // \u plus four hex digits of mixed case
    task automatic put_quad(logic [15:0] v);
        str_bytes.push_back(CH_BSLASH);
        str_bytes.push_back(CH_U);
        for (int i = 3; i >= 0; i--)
            str_bytes.push_back(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    // ------------------------------------------------------------------
    // result side: compare every accepted beat with the oldest prediction
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_beat_t got;
        result_beat_t want;
        if (rst_n && pop && !empty)
        begin
            got = {out_byte, out_valid, run_last, string_done, error_code, err_offset};
            if (predicted_beats.size() == 0)
            begin
                n_fail++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
            end
            else
            begin
                want = predicted_beats.pop_front();
                check_field("out_byte", 32'(want.data), 32'(got.data));
                check_field("out_valid", 32'(want.valid), 32'(got.valid));
                check_field("run_last", 32'(want.run_last), 32'(got.run_last));
                check_field("string_done", 32'(want.done), 32'(got.done));
                check_field("error_code", 32'(want.err), 32'(got.err));
                check_field("err_offset", 32'(want.off), 32'(got.off));
            end
        end
    end

    // receiver: random pop gaps, one stretch of steady pops, and one long hold-off that
    // lets the job queue fill so full backs up into the sender
    initial
    begin : receiver
        int rx_cyc;
        rx_cyc = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            rx_cyc++;
            if (rx_cyc >= 60 && rx_cyc < 140)
                pop <= 1'b0;
            else if (rx_cyc >= 160 && rx_cyc < 300)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 99) >= 14);
        end
    end

    // overall time limit, far beyond the slowest legal run
    initial
    begin : watchdog
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus, sender and end of run
    // ------------------------------------------------------------------

    initial
    begin : main
        int         idx;
        int         tx_cyc;
        int         n_random;
        int         n_seg;
        int         kind;
        int         sub;
        int         cut;
        int unsigned v;
        logic       close_empty;
        logic [7:0] b;
        stim_beat_t cur;

        reset_parser();

        // directed table
        // empty string: only a closing beat with no byte
        add_pinned(8'hff, 1'b1, 1'b1, only_beat(8'h00, 1'b0, 1'b1, ERR_NONE, 0));
        // byte extremes around a simple escape and an ignored empty beat
        add_pinned(8'h00, 1'b0, 1'b0, only_beat(8'h00, 1'b1, 1'b0, ERR_NONE, 0));
        add_beat(CH_BSLASH, 1'b0, 1'b0);
        add_beat(8'h6e, 1'b0, 1'b0);
        add_beat(8'h5a, 1'b0, 1'b1);
        add_pinned(8'hff, 1'b1, 1'b0, only_beat(8'hff, 1'b1, 1'b1, ERR_NONE, 0));
        // invalid escape letter, then the tail of the string is dropped
        add_beat(CH_BSLASH, 1'b0, 1'b0);
        add_pinned(8'h71, 1'b0, 1'b0, only_beat(8'h00, 1'b0, 1'b1, ERR_ESCAPE, 1));
        add_beat(8'h7a, 1'b1, 1'b0);
        // trailing backslash
        add_pinned(CH_BSLASH, 1'b1, 1'b0, only_beat(8'h00, 1'b0, 1'b1, ERR_ESCAPE, 0));
        // lone low surrogate \uDC00
        add_beat(CH_BSLASH, 1'b0, 1'b0);
        add_beat(CH_U, 1'b0, 1'b0);
        add_beat(8'h44, 1'b0, 1'b0);
        add_beat(8'h43, 1'b0, 1'b0);
        add_beat(8'h30, 1'b0, 1'b0);
        add_pinned(8'h30, 1'b1, 1'b0, only_beat(8'h00, 1'b0, 1'b1, ERR_UNICODE, 2));
        // short quad: string ends right after \u
        add_beat(CH_BSLASH, 1'b0, 1'b0);
        add_pinned(CH_U, 1'b1, 1'b0, only_beat(8'h00, 1'b0, 1'b1, ERR_UNICODE, 2));
        // bad hex digit held until the quad completes: \uGFFF
        add_beat(CH_BSLASH, 1'b0, 1'b0);
        add_beat(CH_U, 1'b0, 1'b0);
        add_beat(8'h47, 1'b0, 1'b0);
        add_beat(8'h46, 1'b0, 1'b0);
        add_beat(8'h46, 1'b0, 1'b0);
        add_pinned(8'h46, 1'b1, 1'b0, only_beat(8'h00, 1'b0, 1'b1, ERR_UNICODE, 2));
        // unpaired high surrogate \udbff followed by a plain byte
        add_beat(CH_BSLASH, 1'b0, 1'b0);
        add_beat(CH_U, 1'b0, 1'b0);
        add_beat(8'h64, 1'b0, 1'b0);
        add_beat(8'h62, 1'b0, 1'b0);
        add_beat(8'h66, 1'b0, 1'b0);
        add_beat(8'h66, 1'b0, 1'b0);
        add_pinned(8'h78, 1'b1, 1'b0, only_beat(8'h00, 1'b0, 1'b1, ERR_UNICODE, 6));

        // random strings: mostly well-formed escapes with random content,
        // some broken sequences and truncated strings
        n_random = 0;
        while (n_random < N_RANDOM_BEATS)
        begin
            str_bytes.delete();
            n_seg = ($urandom_range(0, 11) == 0) ? 0 : int'($urandom_range(1, 6));
            for (int s = 0; s < n_seg; s++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 40)
                begin
                    b = 8'($urandom_range(0, 255));
                    // a raw backslash goes in as the escaped form
                    if (b == CH_BSLASH)
                        str_bytes.push_back(CH_BSLASH);
                    str_bytes.push_back(b);
                end
                else if (kind < 60)
                begin
                    str_bytes.push_back(CH_BSLASH);
                    str_bytes.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
                end
                else if (kind < 75)
                begin
                    // one, two or three utf-8 bytes, skipping the surrogate range
                    case ($urandom_range(0, 3))
                        0:       v = $urandom_range(0, 32'h7f);
                        1:       v = $urandom_range(32'h80, 32'h7ff);
                        2:       v = $urandom_range(32'h800, 32'hd7ff);
                        default: v = $urandom_range(32'he000, 32'hffff);
                    endcase
                    put_quad(16'(v));
                end
                else if (kind < 90)
                begin
                    put_quad(16'($urandom_range(32'hd800, 32'hdbff)));
                    put_quad(16'($urandom_range(32'hdc00, 32'hdfff)));
                end
                else
                begin
                    sub = $urandom_range(0, 5);
                    case (sub)
                        0:
                        begin
                            // backslash and any byte
                            str_bytes.push_back(CH_BSLASH);
                            str_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        1:
                        begin
                            // quad with one digit replaced by a random byte
                            put_quad(16'($urandom_range(0, 32'hffff)));
                            cut = $urandom_range(0, 3);
                            str_bytes[str_bytes.size() - 1 - cut] = 8'($urandom_range(0, 255));
                        end
                        2: put_quad(16'($urandom_range(32'hdc00, 32'hdfff)));
                        default:
                        begin
                            // high surrogate with a broken follow-up
                            put_quad(16'($urandom_range(32'hd800, 32'hdbff)));
                            if (sub == 3)
                            begin
                                str_bytes.push_back(8'($urandom_range(0, 255)));
                            end
                            else if (sub == 4)
                            begin
                                str_bytes.push_back(CH_BSLASH);
                                str_bytes.push_back(8'($urandom_range(0, 255)));
                            end
                            else
                            begin
                                put_quad(16'($urandom_range(0, 32'hffff)));
                            end
                        end
                    endcase
                end
            end
            // cut the string short somewhere, possibly mid-escape
            if (str_bytes.size() > 1 && $urandom_range(0, 99) < 8)
            begin
                cut = $urandom_range(1, str_bytes.size() - 1);
                while (str_bytes.size() > cut)
                    void'(str_bytes.pop_back());
            end
            close_empty = (str_bytes.size() == 0) || ($urandom_range(0, 99) < 10);
            foreach (str_bytes[i])
            begin
                if ($urandom_range(0, 99) < 3)
                    add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                add_beat(str_bytes[i], !close_empty && (i == str_bytes.size() - 1), 1'b0);
                n_random++;
            end
            if (close_empty)
            begin
                add_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                n_random++;
            end
        end

        // reset once
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender: one push decision per falling edge, acceptance seen at the rising edge
        idx    = 0;
        tx_cyc = 0;
        @(negedge clk);
        while (idx < stim_q.size())
        begin
            tx_cyc++;
            if (($urandom_range(0, 99) < 14) && !(tx_cyc >= 50 && tx_cyc < 120))
            begin
                push <= 1'b0;
            end
            else
            begin
                push    <= 1'b1;
                in_byte <= stim_q[idx].data;
                last_in <= stim_q[idx].last;
                no_byte <= stim_q[idx].nob;
            end
            @(posedge clk);
            if (push && !full)
            begin
                cur = stim_q[idx];
                unescape_beat(cur.data, cur.last, cur.nob);
                if (cur.pinned)
                    predicted_beats.push_back(cur.pin);
                else
                    foreach (step_beats[i])
                        predicted_beats.push_back(step_beats[i]);
                idx++;
            end
            @(negedge clk);
        end
        push <= 1'b0;

        // drain, then keep clocking to catch stray beats
        while (predicted_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (n_fail == 0 && predicted_beats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
tb/sv/json_string_unescape_utf8_tb.sv
